// File: rtl/qsb_pkg.sv
// shared types and constants for the quicksort buffer sorter
`timescale 1ns / 1ps

package qsb_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } qsb_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_result;
    } qsb_out_t;

    // one sorted value leaving the engine toward the output register
    typedef struct packed {
        logic     valid;
        qsb_out_t item;
    } qsb_emit_t;

endpackage

// File: rtl/quicksort_buffer_sorter.sv
// top level: sort engine plus the output register
//
// Input channel (in_valid / in_ready / in_data) takes one signed value per
// transfer. in_data.last_item ends the set; the transfer that fills the
// buffer (MAX_ITEMS values) ends it as well. Loading takes one value per
// cycle. When a set ends the block sorts it in place by quicksort, using a
// single value memory with a registered read port and a memory of pending
// ranges. Each compare is a read state followed by a check state. The result
// channel (out_valid / out_ready / out_data) then gives the sorted values in
// ascending order; each value is read from the memory only while the output
// register is free and is then handed over to it. out_data.last_result marks
// the greatest. While sorting or emitting, in_ready is low. A stall on the
// result side holds the output register and pauses the reads; the next set
// may start loading while the final value still waits to be taken. Reset
// empties the buffer and drops any result.
`timescale 1ns / 1ps

module quicksort_buffer_sorter
    import qsb_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  qsb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output qsb_out_t out_data
);

    qsb_emit_t emit;
    logic      out_free;
    logic      out_valid_reg;
    qsb_out_t  out_data_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    qsb_sort_engine #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_free (out_free),
        .emit     (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_data_reg <= emit.item;
        end
    end

    // engine only hands over a value when the register was free to take it
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> $past(out_free))
    else $error("value emitted into a busy output register");

    // the final value of a run returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.item.last_result |=> in_ready)
    else $error("not back to loading after the final value");

    // no value is emitted while input transfers are open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !emit.valid)
    else $error("emit while loading");

endmodule

// File: rtl/qsb_sort_engine.sv
// value store, range stack and the load / partition / emit sequencer
`timescale 1ns / 1ps

module qsb_sort_engine
    import qsb_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  qsb_in_t   in_data,
    input  logic      out_free,
    output qsb_emit_t emit
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } range_t;

    typedef enum logic [11:0] {
        S_LOAD      = 12'b0000_0000_0001,
        S_POP       = 12'b0000_0000_0010,
        S_POP_WAIT  = 12'b0000_0000_0100,
        S_PIVOT     = 12'b0000_0000_1000,
        S_HI_RD     = 12'b0000_0001_0000,
        S_HI_CHK    = 12'b0000_0010_0000,
        S_LO_RD     = 12'b0000_0100_0000,
        S_LO_CHK    = 12'b0000_1000_0000,
        S_PLACE     = 12'b0001_0000_0000,
        S_PUSH      = 12'b0010_0000_0000,
        S_EMIT_RD   = 12'b0100_0000_0000,
        S_EMIT_WAIT = 12'b1000_0000_0000
    } state_t;

    logic signed [VALUE_W-1:0] value_mem [MAX_ITEMS];
    range_t                    stack_mem [MAX_ITEMS];

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          sp_reg, sp_next;
    logic [IDX_W-1:0]          last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic [IDX_W-1:0]          range_lo_reg, range_lo_next;
    logic [IDX_W-1:0]          range_hi_reg, range_hi_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic signed [VALUE_W-1:0] pivot_reg, pivot_next;
    logic signed [VALUE_W-1:0] store_rdata_reg;
    range_t                    stack_rdata_reg;

    logic                      store_we;
    logic [IDX_W-1:0]          store_waddr;
    logic signed [VALUE_W-1:0] store_wdata;
    logic [IDX_W-1:0]          store_raddr;
    logic                      stack_we;
    logic [IDX_W-1:0]          stack_waddr;
    range_t                    stack_wdata;
    logic [CNT_W-1:0]          sp_dec;
    logic [IDX_W-1:0]          stack_raddr;
    logic [IDX_W:0]            mid_inc;
    logic [IDX_W:0]            lo_inc;

    assign sp_dec      = sp_reg - CNT_W'(1);
    assign stack_raddr = sp_dec[IDX_W-1:0];
    assign mid_inc     = {1'b0, lo_reg} + (IDX_W + 1)'(1);
    assign lo_inc      = {1'b0, range_lo_reg} + (IDX_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            value_mem[store_waddr] <= store_wdata;
        end
        store_rdata_reg <= value_mem[store_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        sp_next       = sp_reg;
        last_idx_next = last_idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        range_lo_next = range_lo_reg;
        range_hi_next = range_hi_reg;
        k_next        = k_reg;
        pivot_next    = pivot_reg;
        store_we      = 1'b0;
        store_waddr   = lo_reg;
        store_wdata   = pivot_reg;
        store_raddr   = lo_reg;
        stack_we      = 1'b0;
        stack_waddr   = sp_reg[IDX_W-1:0];
        stack_wdata   = '{hi: range_hi_reg, lo: mid_inc[IDX_W-1:0]};
        in_ready      = 1'b0;
        emit          = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    store_we    = 1'b1;
                    store_waddr = count_reg[IDX_W-1:0];
                    store_wdata = in_data.value;
                    if (in_data.last_item || count_reg == CNT_W'(MAX_ITEMS - 1))
                    begin
                        last_idx_next = count_reg[IDX_W-1:0];
                        k_next        = '0;
                        if (count_reg == '0)
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            // the whole loaded set is the first range
                            stack_we    = 1'b1;
                            stack_waddr = '0;
                            stack_wdata = '{hi: count_reg[IDX_W-1:0], lo: '0};
                            sp_next     = CNT_W'(1);
                            state_next  = S_POP;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                lo_next       = stack_rdata_reg.lo;
                hi_next       = stack_rdata_reg.hi;
                range_lo_next = stack_rdata_reg.lo;
                range_hi_next = stack_rdata_reg.hi;
                store_raddr   = stack_rdata_reg.lo;
                if (stack_rdata_reg.lo >= stack_rdata_reg.hi)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_PIVOT;
                end
            end
            S_PIVOT:
            begin
                pivot_next = store_rdata_reg;
                state_next = S_HI_RD;
            end
            S_HI_RD:
            begin
                store_raddr = hi_reg;
                state_next  = (lo_reg < hi_reg) ? S_HI_CHK : S_PLACE;
            end
            S_HI_CHK:
            begin
                if (store_rdata_reg >= pivot_reg)
                begin
                    hi_next    = hi_reg - IDX_W'(1);
                    state_next = S_HI_RD;
                end
                else
                begin
                    // fill the hole on the left
                    store_we    = 1'b1;
                    store_waddr = lo_reg;
                    store_wdata = store_rdata_reg;
                    state_next  = S_LO_RD;
                end
            end
            S_LO_RD:
            begin
                store_raddr = lo_reg;
                state_next  = (lo_reg < hi_reg) ? S_LO_CHK : S_PLACE;
            end
            S_LO_CHK:
            begin
                if (store_rdata_reg <= pivot_reg)
                begin
                    lo_next    = lo_reg + IDX_W'(1);
                    state_next = S_LO_RD;
                end
                else
                begin
                    store_we    = 1'b1;
                    store_waddr = hi_reg;
                    store_wdata = store_rdata_reg;
                    state_next  = S_HI_RD;
                end
            end
            S_PLACE:
            begin
                store_we    = 1'b1;
                store_waddr = lo_reg;
                store_wdata = pivot_reg;
                if (mid_inc < {1'b0, range_hi_reg})
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + CNT_W'(1);
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                stack_wdata = '{hi: lo_reg - IDX_W'(1), lo: range_lo_reg};
                if ({1'b0, lo_reg} > lo_inc)
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + CNT_W'(1);
                end
                state_next = S_POP;
            end
            S_EMIT_RD:
            begin
                store_raddr = k_reg;
                if (out_free)
                begin
                    state_next = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT:
            begin
                emit.valid             = 1'b1;
                emit.item.sorted_value = store_rdata_reg;
                emit.item.last_result  = (k_reg == last_idx_reg);
                if (k_reg == last_idx_reg)
                begin
                    count_next = '0;
                    sp_next    = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            sp_reg    <= '0;
            pivot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sp_reg    <= sp_next;
            pivot_reg <= pivot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg <= last_idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        range_lo_reg <= range_lo_next;
        range_hi_reg <= range_hi_next;
        k_reg        <= k_next;
    end

endmodule
